@@ rtl/scc_pkg.sv @@
// Shared types and constants for the segment crossing counter.
package scc_pkg;

	localparam int COORD_W    = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int COUNT_W    = 16;
	localparam int S_TDATA_W  = 4 * COORD_W;
	localparam int M_TDATA_W  = 24;
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W     = 3;
	localparam int QCNT_W     = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	// query register indexes on the config port
	typedef enum logic [1:0] {
		REG_START_X = 2'd0,
		REG_START_Y = 2'd1,
		REG_END_X   = 2'd2,
		REG_END_Y   = 2'd3
	} cfg_reg_t;

	// classified word handed from the front end to the queue
	typedef struct packed {
		logic valid;
		logic hit;
		logic last;
	} cls_t;

endpackage

@@ rtl/scc_front.sv @@
// Front end: query registers and the three-stage crossing test pipeline.
module scc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [scc_pkg::COORD_W-1:0]      cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [scc_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic                             s_tlast,
	input  logic [scc_pkg::QCNT_W-1:0]       q_used,
	output scc_pkg::cls_t                    cls
);

	scc_pkg::coord_t px_q, py_q, qx_q, qy_q;
	scc_pkg::coord_t ax, ay, bx, by;
	logic            accept;

	scc_pkg::diff_t  d_s1 [12];
	logic            ovl_s1, last_s1, valid_s1;
	scc_pkg::prod_t  m_s2 [8];
	logic            ovl_s2, last_s2, valid_s2;
	logic            gt [4];
	logic            lt [4];
	logic            hit;
	logic            valid_s3, hit_s3, last_s3;
	logic [1:0]      inflight;
	logic [scc_pkg::QCNT_W-1:0] occ;

	function automatic scc_pkg::diff_t sub(scc_pkg::coord_t a, scc_pkg::coord_t b);
		scc_pkg::diff_t ae, be;
		ae = {a[scc_pkg::COORD_W-1], a};
		be = {b[scc_pkg::COORD_W-1], b};
		return ae - be;
	endfunction

	// closed intervals overlap unless one lies wholly below the other
	function automatic logic overlap(scc_pkg::coord_t a0, scc_pkg::coord_t a1,
			scc_pkg::coord_t b0, scc_pkg::coord_t b1);
		logic a_below, b_below;
		a_below = (a0 < b0) && (a0 < b1) && (a1 < b0) && (a1 < b1);
		b_below = (b0 < a0) && (b0 < a1) && (b1 < a0) && (b1 < a1);
		return !a_below && !b_below;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
		end else if (cfg_valid) begin
			case (scc_pkg::cfg_reg_t'(cfg_index))
				scc_pkg::REG_START_X: px_q <= cfg_data;
				scc_pkg::REG_START_Y: py_q <= cfg_data;
				scc_pkg::REG_END_X:   qx_q <= cfg_data;
				scc_pkg::REG_END_Y:   qy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ax = s_tdata[31:0];
	assign ay = s_tdata[63:32];
	assign bx = s_tdata[95:64];
	assign by = s_tdata[127:96];

	// credit check: every word in flight has a queue slot waiting
	assign inflight = 2'(valid_s1) + 2'(valid_s2) + 2'(valid_s3);
	assign occ      = scc_pkg::QCNT_W'(inflight) + q_used;
	assign s_tready = occ < scc_pkg::QCNT_W'(scc_pkg::QUEUE_DEPTH);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// s1: edge vectors and projection overlap
	always_ff @(posedge clk) begin
		d_s1[0]  <= sub(qx_q, px_q);
		d_s1[1]  <= sub(qy_q, py_q);
		d_s1[2]  <= sub(ax, px_q);
		d_s1[3]  <= sub(ay, py_q);
		d_s1[4]  <= sub(bx, px_q);
		d_s1[5]  <= sub(by, py_q);
		d_s1[6]  <= sub(bx, ax);
		d_s1[7]  <= sub(by, ay);
		d_s1[8]  <= sub(px_q, ax);
		d_s1[9]  <= sub(py_q, ay);
		d_s1[10] <= sub(qx_q, ax);
		d_s1[11] <= sub(qy_q, ay);
		ovl_s1   <= overlap(px_q, qx_q, ax, bx) && overlap(py_q, qy_q, ay, by);
		last_s1  <= s_tlast;
	end

	// s2: the two halves of each of the four cross products
	always_ff @(posedge clk) begin
		m_s2[0] <= d_s1[0] * d_s1[3];
		m_s2[1] <= d_s1[1] * d_s1[2];
		m_s2[2] <= d_s1[0] * d_s1[5];
		m_s2[3] <= d_s1[1] * d_s1[4];
		m_s2[4] <= d_s1[6] * d_s1[9];
		m_s2[5] <= d_s1[7] * d_s1[8];
		m_s2[6] <= d_s1[6] * d_s1[11];
		m_s2[7] <= d_s1[7] * d_s1[10];
		ovl_s2  <= ovl_s1;
		last_s2 <= last_s1;
	end

	// s3: side signs; a pair strictly on one side rejects the candidate
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			gt[i] = m_s2[2*i] > m_s2[2*i+1];
			lt[i] = m_s2[2*i] < m_s2[2*i+1];
		end
		hit = ovl_s2
			&& !((gt[0] && gt[1]) || (lt[0] && lt[1]))
			&& !((gt[2] && gt[3]) || (lt[2] && lt[3]));
	end

	always_ff @(posedge clk) begin
		hit_s3  <= hit;
		last_s3 <= last_s2;
	end

	assign cls = '{valid: valid_s3, hit: hit_s3, last: last_s3};

endmodule

@@ rtl/scc_back.sv @@
// Back end: result queue, saturating set counter and output register.
module scc_back #(
	parameter logic [scc_pkg::COUNT_W-1:0] CountCap = 16'hFFFF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  scc_pkg::cls_t                   cls,
	output logic [scc_pkg::QCNT_W-1:0]      q_used,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [scc_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tlast
);

	logic [1:0]                  mem_q [scc_pkg::QUEUE_DEPTH];
	logic [scc_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [scc_pkg::QCNT_W-1:0]  used_q;
	logic                        pop;
	logic                        pop_hit, pop_last;
	logic [scc_pkg::COUNT_W-1:0] run_cnt_q, new_cnt, count_q;
	logic                        crosses_q, last_q, valid_q;

	assign q_used   = used_q;
	assign pop      = (used_q != '0) && (!valid_q || m_tready);
	assign pop_hit  = mem_q[rd_ptr_q][1];
	assign pop_last = mem_q[rd_ptr_q][0];
	assign new_cnt  = (pop_hit && run_cnt_q < CountCap) ? run_cnt_q + 1'b1 : run_cnt_q;

	always_ff @(posedge clk) begin
		if (cls.valid)
			mem_q[wr_ptr_q] <= {cls.hit, cls.last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			used_q    <= '0;
			run_cnt_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (cls.valid)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			used_q <= used_q + scc_pkg::QCNT_W'(cls.valid) - scc_pkg::QCNT_W'(pop);
			if (pop) begin
				valid_q   <= 1'b1;
				run_cnt_q <= pop_last ? '0 : new_cnt;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			crosses_q <= pop_hit;
			count_q   <= new_cnt;
			last_q    <= pop_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'b0, count_q, crosses_q};
	assign m_tlast  = last_q;

endmodule

@@ rtl/segment_crossing_counter.sv @@
// Path: each input word passes the s1, s2 and s3 registers, the result queue and the output register.
// Throughput: one word per cycle while s_tready is high; the three-stage test pipeline feeds an 8-entry queue.
// Input stalls only when the queue and pipeline together hold 8 words (output backpressure).
// Reset (arst_n low, asynchronous): query registers and set count clear to zero,
// pipeline, queue and output register empty. No clearing pass is needed.
module segment_crossing_counter #(
	parameter longint unsigned COUNT_MAX = 65535
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write: index 0 start_x, 1 start_y, 2 end_x, 3 end_y
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [scc_pkg::COORD_W-1:0]     cfg_data,
	// candidate segment stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [scc_pkg::S_TDATA_W-1:0]   s_tdata,  // seg_a_x, seg_a_y, seg_b_x, seg_b_y
	input  logic                            s_tlast,  // last_segment
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [scc_pkg::M_TDATA_W-1:0]   m_tdata,  // crosses, crossing_count[15:0], zero pad
	output logic                            m_tlast   // is_final
);

	// count saturates at the lesser of COUNT_MAX and the 16-bit limit
	localparam logic [scc_pkg::COUNT_W-1:0] CountCap =
		(COUNT_MAX < 64'd65535) ? COUNT_MAX[scc_pkg::COUNT_W-1:0] : {scc_pkg::COUNT_W{1'b1}};

	scc_pkg::cls_t               cls;
	logic [scc_pkg::QCNT_W-1:0]  q_used;

	// front: query regs, bounding-box overlap, cross-product side tests
	scc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_used    (q_used),
		.cls       (cls)
	);

	// back: queue of test results, running count, output word
	scc_back #(
		.CountCap (CountCap)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cls      (cls),
		.q_used   (q_used),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/scc_checker.sv @@
// Port-level checks for the segment crossing counter, bound to the top level.
module scc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [scc_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                            m_tlast
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// a crossing always leaves a nonzero count
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[16:1] != 16'd0)
		else $error("crossing reported with zero count");

	// nothing comes out right after reset release
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid straight out of reset");

	// a first result after set end with no crossing shows a zero count
	a_set_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast ##1 m_tvalid && !m_tdata[0] && $past(m_tvalid)
			|-> m_tdata[16:1] == 16'd0)
		else $error("count not cleared after set end");

endmodule

bind segment_crossing_counter scc_checker u_scc_checker (.*);
